### hw/rtl/longest_prefix_match_table_top_macros.svh
// assertion helpers for the route table, sampled on i_clk, off while in reset
`ifndef LONGEST_PREFIX_MATCH_TABLE_TOP_MACROS_SVH
`define LONGEST_PREFIX_MATCH_TABLE_TOP_MACROS_SVH

// consequence holds in the same cycle as the condition
`define LPMT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the condition
`define LPMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lpmt_pkg.sv
package lpmt_pkg;

    // fixed field widths
    localparam int LPMT_ADDR_W        = 32;
    localparam int LPMT_IFC_W         = 8;
    localparam int LPMT_LEN_W         = 6;
    localparam int LPMT_ROUTE_ENTRIES = 64;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef logic [LPMT_LEN_W-1:0] t_len;

    // one command transfer
    typedef struct packed {
        logic                   action;
        logic [LPMT_ADDR_W-1:0] address;
        logic [LPMT_ADDR_W-1:0] mask;
        logic [LPMT_ADDR_W-1:0] next_hop_in;
        logic [LPMT_IFC_W-1:0]  interface_in;
    } t_in_item;

    // one result transfer
    typedef struct packed {
        logic                   found;
        logic [LPMT_IFC_W-1:0]  interface_out;
        logic [LPMT_ADDR_W-1:0] next_hop_out;
        logic                   table_full;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } t_ctl_status;

    // number of one bits in a mask, summed per byte then across bytes
    function automatic t_len ones_count(input logic [LPMT_ADDR_W-1:0] v);
        logic [3:0] part [4];
        t_len       total;
        total = '0;
        for (int b = 0; b < 4; b++) begin
            part[b] = '0;
            for (int k = 0; k < 8; k++) begin
                part[b] = part[b] + 4'(v[8*b+k]);
            end
        end
        for (int b = 0; b < 4; b++) begin
            total = total + t_len'(part[b]);
        end
        return total;
    endfunction

    // mask with the top len bits set
    function automatic logic [LPMT_ADDR_W-1:0] lead_mask(input t_len len);
        logic [LPMT_ADDR_W-1:0] m;
        if (len >= t_len'(LPMT_ADDR_W)) begin
            m = '1;
        end else begin
            m = ~({LPMT_ADDR_W{1'b1}} >> len);
        end
        return m;
    endfunction

endpackage

### hw/rtl/lpmt_ctrl.sv
module lpmt_ctrl
    import lpmt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_ctl_status i_status,
    output t_ctl_cmd    o_ctl,
    output logic        busy,
    output logic        o_done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state r_state;
    logic   r_done;

    // commands follow the state
    assign o_ctl.load   = start && (r_state == ST_IDLE);
    assign o_ctl.scan   = (r_state == ST_SCAN);
    assign o_ctl.finish = (r_state == ST_FINISH);
    assign busy         = (r_state != ST_IDLE);
    assign o_done       = r_done;

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (i_status.scan_done) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    r_state <= ST_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/lpmt_datapath.sv
module lpmt_datapath
    import lpmt_pkg::*;
#(
    parameter int ROUTE_ENTRIES = LPMT_ROUTE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_cmd,
    input  t_ctl_cmd    i_ctl,
    output t_ctl_status o_status,
    output t_out_item   o_result
);

    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ROUTE_ENTRIES);

    typedef struct packed {
        logic [LPMT_ADDR_W-1:0] prefix;
        t_len                   length;
        logic [LPMT_ADDR_W-1:0] hop_addr;
        logic [LPMT_IFC_W-1:0]  ifc;
    } t_entry;

    // route memory, filled from slot 0 upward, never freed
    t_entry r_mem [ROUTE_ENTRIES];

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_rd_idx;
    logic                   r_rd_vld;
    t_entry                 r_rd_data;
    logic [IDX_W-1:0]       r_rd_ent_idx;

    logic                   r_action;
    logic [LPMT_ADDR_W-1:0] r_addr;
    t_len                   r_len;
    logic [LPMT_ADDR_W-1:0] r_nh;
    logic [LPMT_IFC_W-1:0]  r_ifc;

    logic                   r_hit;
    logic [IDX_W-1:0]       r_hit_idx;
    t_len                   r_best_len;
    logic [LPMT_ADDR_W-1:0] r_best_nh;
    logic [LPMT_IFC_W-1:0]  r_best_ifc;
    t_out_item              r_result;

    logic [LPMT_ADDR_W-1:0] w_pfx;
    logic                   w_rd_en;
    logic                   w_lkp_match;
    logic                   w_ins_match;
    logic                   w_ins_ok;
    logic                   w_is_full;
    logic                   w_wr_en;
    logic                   w_wr_new;
    logic [IDX_W-1:0]       w_waddr;
    t_entry                 w_wdata;

    // insert prefix with host bits cleared
    assign w_pfx = r_addr & lead_mask(r_len);

    // one entry read a cycle while below the fill count
    assign w_rd_en = i_ctl.scan && (r_rd_idx != r_count);

    // entry compares
    assign w_lkp_match = ((r_addr & lead_mask(r_rd_data.length)) == r_rd_data.prefix)
                      && (r_rd_data.length > r_best_len);
    assign w_ins_match = (r_rd_data.length == r_len) && (r_rd_data.prefix == w_pfx);

    // insert write decision
    assign w_ins_ok  = (r_action == ACT_INSERT) && (r_len != '0);
    assign w_is_full = (r_count == FULL_COUNT);
    assign w_wr_en   = i_ctl.finish && w_ins_ok && (r_hit || !w_is_full);
    assign w_wr_new  = w_wr_en && !r_hit;
    assign w_waddr   = r_hit ? r_hit_idx : r_count[IDX_W-1:0];

    assign w_wdata.prefix   = w_pfx;
    assign w_wdata.length   = r_len;
    assign w_wdata.hop_addr = r_nh;
    assign w_wdata.ifc      = r_ifc;

    assign o_status.scan_done = !r_rd_vld && (r_rd_idx == r_count);
    assign o_result           = r_result;

    // command capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_action <= i_cmd.action;
            r_addr   <= i_cmd.address;
            r_len    <= ones_count(i_cmd.mask);
            r_nh     <= i_cmd.next_hop_in;
            r_ifc    <= i_cmd.interface_in;
        end
    end

    // scan counter and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_rd_en;
            if (i_ctl.load) begin
                r_rd_idx <= '0;
            end else if (w_rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (w_wr_new) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // route memory port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_data    <= r_mem[r_rd_idx[IDX_W-1:0]];
            r_rd_ent_idx <= r_rd_idx[IDX_W-1:0];
        end
    end

    // match tracking, longest wins, lowest index on ties
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_hit      <= 1'b0;
            r_best_len <= '0;
            r_best_nh  <= '0;
            r_best_ifc <= '0;
        end else if (i_ctl.scan && r_rd_vld) begin
            if (r_action == ACT_LOOKUP) begin
                if (w_lkp_match) begin
                    r_hit      <= 1'b1;
                    r_best_len <= r_rd_data.length;
                    r_best_nh  <= r_rd_data.hop_addr;
                    r_best_ifc <= r_rd_data.ifc;
                end
            end else if (!r_hit && w_ins_match) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_ent_idx;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            if (r_action == ACT_LOOKUP) begin
                r_result.found         <= r_hit;
                r_result.interface_out <= r_best_ifc;
                r_result.next_hop_out  <= r_best_nh;
                r_result.table_full    <= 1'b0;
            end else begin
                r_result.found         <= 1'b0;
                r_result.interface_out <= '0;
                r_result.next_hop_out  <= '0;
                r_result.table_full    <= w_ins_ok && !r_hit && w_is_full;
            end
        end
    end

endmodule

### hw/rtl/longest_prefix_match_table_top.sv
// IPv4 route table with longest prefix match. A command is taken when start
// is high and busy is low; its result shows on o_result for exactly one cycle
// with o_done high and must be captured then, since the receiver cannot stall.
// Routes sit in one memory read one entry per cycle, so the time from acceptance
// to o_done grows with the number of stored routes, and the scan over them sets
// it. A new command may be issued in the cycle o_done is high. Routes are never
// removed and the table is empty after reset, with no clearing pass. An insert
// with a zero mask stores nothing and reports no error; an insert of a new route
// into a full table reports table_full.
`include "longest_prefix_match_table_top_macros.svh"

module longest_prefix_match_table_top
    import lpmt_pkg::*;
#(
    parameter int ROUTE_ENTRIES = LPMT_ROUTE_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_cmd,
    output logic      busy,
    output logic      o_done,
    output t_out_item o_result
);

    t_ctl_cmd    w_ctl;
    t_ctl_status w_status;

    // sequencing
    lpmt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_ctl    (w_ctl),
        .busy     (busy),
        .o_done   (o_done)
    );

    // route storage and compare
    lpmt_datapath #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (w_ctl),
        .o_status (w_status),
        .o_result (o_result)
    );

    // checks
    `LPMT_ASSERT_SAME(a_done_idle, o_done, !busy, "result strobe while busy")
    `LPMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command not busy")
    `LPMT_ASSERT_NEXT(a_finish_done, w_ctl.finish, o_done, "finish without result strobe")
    `LPMT_ASSERT_SAME(a_full_clean, o_done && o_result.table_full, !o_result.found && (o_result.next_hop_out == '0), "full insert with route data")

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import lpmt_pkg::*;

    localparam int ENTRIES      = LPMT_ROUTE_ENTRIES;
    localparam int RANDOM_ITEMS = 1550;
    localparam int POOL_SIZE    = 96;
    localparam int CYCLE_LIMIT  = 900000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PRINT_CAP    = 60;
    localparam int IN_W         = $bits(t_in_item);

    typedef struct {
        t_in_item  cmd;
        bit        typed;
        t_out_item res;
    } t_directed_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_cmd;
    logic      busy;
    logic      o_done;
    t_out_item o_result;

    // predicted copy of the route table
    logic                   route_valid     [ENTRIES];
    logic [LPMT_ADDR_W-1:0] route_prefix    [ENTRIES];
    int                     route_length    [ENTRIES];
    logic [LPMT_ADDR_W-1:0] route_hop_addr  [ENTRIES];
    logic [LPMT_IFC_W-1:0]  route_interface [ENTRIES];

    // prefixes that random inserts and lookups draw from
    logic [LPMT_ADDR_W-1:0] pool_addr [POOL_SIZE];
    int                     pool_len  [POOL_SIZE];

    t_out_item     pending_results [$];
    t_directed_row directed_rows   [$];
    int            mismatch_count = 0;
    int            cycle_count = 0;

    longest_prefix_match_table_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // top len bits set, len is 1..32
    function automatic logic [LPMT_ADDR_W-1:0] prefix_mask(input int len);
        if (len >= LPMT_ADDR_W) begin
            return '1;
        end
        return ~(32'hFFFF_FFFF >> len);
    endfunction

    // apply one command to the predicted table and return its result
    function automatic t_out_item route_predict(input t_in_item cmd);
        t_out_item              res;
        int                     len;
        int                     hit_slot;
        int                     free_slot;
        int                     best;
        logic [LPMT_ADDR_W-1:0] pfx;
        res = '0;
        if (cmd.action == ACT_INSERT) begin
            len = $countones(cmd.mask);
            if (len != 0) begin
                pfx       = cmd.address & prefix_mask(len);
                hit_slot  = -1;
                free_slot = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (route_valid[i]) begin
                        if (hit_slot < 0 && route_length[i] == len && route_prefix[i] == pfx) begin
                            hit_slot = i;
                        end
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (hit_slot < 0) begin
                    hit_slot = free_slot;
                end
                if (hit_slot < 0) begin
                    res.table_full = 1'b1;
                end else begin
                    route_valid[hit_slot]     = 1'b1;
                    route_prefix[hit_slot]    = pfx;
                    route_length[hit_slot]    = len;
                    route_hop_addr[hit_slot]  = cmd.next_hop_in;
                    route_interface[hit_slot] = cmd.interface_in;
                end
            end
        end else begin
            best = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (route_valid[i] && route_length[i] > best
                    && (cmd.address & prefix_mask(route_length[i])) == route_prefix[i]) begin
                    best              = route_length[i];
                    res.found         = 1'b1;
                    res.interface_out = route_interface[i];
                    res.next_hop_out  = route_hop_addr[i];
                end
            end
        end
        return res;
    endfunction

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP) begin
            $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    function automatic void add_row(input logic act, input logic [31:0] addr,
                                    input logic [31:0] mask, input logic [31:0] nh,
                                    input logic [7:0] ifc, input bit typed,
                                    input t_out_item res);
        t_directed_row row;
        row.cmd   = '{action: act, address: addr, mask: mask, next_hop_in: nh,
                      interface_in: ifc};
        row.typed = typed;
        row.res   = res;
        directed_rows.push_back(row);
    endfunction

    // random command, shaped toward known prefixes so lookups hit and inserts overwrite
    function automatic t_in_item make_route_cmd(input int idx);
        t_in_item cmd;
        int       k;
        int       len;
        int       pick;
        int       insert_pct;
        cmd.address      = $urandom;
        cmd.mask         = $urandom;
        cmd.next_hop_in  = $urandom;
        cmd.interface_in = 8'($urandom);
        insert_pct       = (idx < 600) ? 15 : 35;
        pick             = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < insert_pct) begin
            cmd.action = ACT_INSERT;
            if (pick < 70) begin
                k           = $urandom_range(0, POOL_SIZE - 1);
                cmd.address = pool_addr[k] | ($urandom & ~prefix_mask(pool_len[k]));
                cmd.mask    = prefix_mask(pool_len[k]);
            end else if (pick < 90) begin
                len      = $urandom_range(1, LPMT_ADDR_W);
                cmd.mask = prefix_mask(len);
            end else if (pick < 95) begin
                // non-contiguous mask, length is its ones count
                cmd.mask = $urandom;
            end else begin
                cmd.mask = '0;
            end
        end else begin
            cmd.action = ACT_LOOKUP;
            if (pick < 65) begin
                k           = $urandom_range(0, POOL_SIZE - 1);
                cmd.address = (pool_addr[k] & prefix_mask(pool_len[k]))
                            | ($urandom & ~prefix_mask(pool_len[k]));
            end
        end
        return cmd;
    endfunction

    // one command transfer; leaves start high at the following falling edge
    task automatic issue_command(input t_in_item cmd, input bit typed, input t_out_item res);
        t_out_item predicted;
        start = 1'b1;
        i_cmd = cmd;
        forever begin
            @(posedge i_clk);
            if (!busy) begin
                break;
            end
        end
        predicted = route_predict(cmd);
        pending_results.push_back(typed ? res : predicted);
        @(negedge i_clk);
    endtask

    // idle for some cycles with junk on the command bus
    task automatic idle_sender(input int cycles);
        start = 1'b0;
        repeat (cycles) begin
            i_cmd = IN_W'({$urandom, $urandom, $urandom, $urandom});
            @(negedge i_clk);
        end
    endtask

    // result check, sampled at the rising edge
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", o_result.next_hop_out, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.found !== want.found) begin
                    report_mismatch("found", 32'(o_result.found), 32'(want.found));
                end
                if (o_result.interface_out !== want.interface_out) begin
                    report_mismatch("interface_out", 32'(o_result.interface_out),
                                    32'(want.interface_out));
                end
                if (o_result.next_hop_out !== want.next_hop_out) begin
                    report_mismatch("next_hop_out", o_result.next_hop_out, want.next_hop_out);
                end
                if (o_result.table_full !== want.table_full) begin
                    report_mismatch("table_full", 32'(o_result.table_full),
                                    32'(want.table_full));
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_out_item none;
        t_in_item  cmd;
        int        burst;
        int        gap;
        int        sent;
        int        src;
        none           = '0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cmd          = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            route_valid[i] = 1'b0;
        end

        // nested prefix pool: some entries derive from earlier ones
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_len[k] = $urandom_range(1, LPMT_ADDR_W);
            if (k > 0 && $urandom_range(0, 1) == 1) begin
                src          = $urandom_range(0, k - 1);
                pool_addr[k] = pool_addr[src] ^ ($urandom >> $urandom_range(8, 31));
            end else begin
                pool_addr[k] = $urandom;
            end
        end

        // directed rows
        add_row(ACT_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 8'h00, 1'b1, none);
        add_row(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, none);
        add_row(ACT_INSERT, 32'hC0A8_0101, 32'h0000_0000, 32'h1111_1111, 8'h11, 1'b1, none);
        add_row(ACT_LOOKUP, 32'hC0A8_0101, 32'h0, 32'h0, 8'h00, 1'b1, none);
        add_row(ACT_INSERT, 32'h0A1B_2C3D, 32'hFF00_0000, 32'h0A00_0001, 8'h01, 1'b1, none);
        add_row(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, none);
        add_row(ACT_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678, 8'h02, 1'b1, none);
        add_row(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h00, 1'b1,
                '{found: 1'b1, interface_out: 8'hFF, next_hop_out: 32'hFFFF_FFFF,
                  table_full: 1'b0});
        add_row(ACT_LOOKUP, 32'hFFFF_FFFE, 32'h0, 32'h0, 8'h00, 1'b1,
                '{found: 1'b1, interface_out: 8'h02, next_hop_out: 32'h1234_5678,
                  table_full: 1'b0});
        add_row(ACT_LOOKUP, 32'h7FFF_FFFF, 32'h0, 32'h0, 8'h00, 1'b1, none);
        add_row(ACT_LOOKUP, 32'h0A00_0000, 32'h0, 32'h0, 8'h00, 1'b1,
                '{found: 1'b1, interface_out: 8'h01, next_hop_out: 32'h0A00_0001,
                  table_full: 1'b0});
        // non-contiguous mask covers the top 16 bits
        add_row(ACT_INSERT, 32'h0A0B_FFFF, 32'h0F0F_0F0F, 32'h0B0B_0B0B, 8'h03, 1'b1, none);
        add_row(ACT_LOOKUP, 32'h0A0B_0001, 32'h0, 32'h0, 8'h00, 1'b0, none);
        // overwrite of an existing /8
        add_row(ACT_INSERT, 32'h0A00_0000, 32'hFF00_0000, 32'hC0FF_EE00, 8'h04, 1'b1, none);
        add_row(ACT_LOOKUP, 32'h0AFF_0000, 32'h0, 32'h0, 8'h00, 1'b0, none);
        add_row(ACT_INSERT, 32'h0A0B_0C00, 32'hFFFF_FF00, 32'h0000_0000, 8'h00, 1'b1, none);
        add_row(ACT_LOOKUP, 32'h0A0B_0C7F, 32'h0, 32'h0, 8'h00, 1'b0, none);
        add_row(ACT_INSERT, 32'h5555_5555, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 8'hAA, 1'b1, none);
        add_row(ACT_LOOKUP, 32'h5555_5554, 32'h0, 32'h0, 8'h00, 1'b0, none);
        add_row(ACT_LOOKUP, 32'h5555_5556, 32'h0, 32'h0, 8'h00, 1'b0, none);
        add_row(ACT_INSERT, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 8'h05, 1'b1, none);
        add_row(ACT_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 8'h00, 1'b0, none);

        // reset
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            issue_command(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].res);
            if ($urandom_range(0, 2) == 0) begin
                idle_sender($urandom_range(1, 70));
            end
        end

        // random bursts with random gaps
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                cmd = make_route_cmd(sent);
                issue_command(cmd, 1'b0, none);
                sent++;
                if (sent == RANDOM_ITEMS / 2) begin
                    // hold off until the table has answered everything
                    start = 1'b0;
                    while (pending_results.size() != 0) begin
                        @(negedge i_clk);
                    end
                end
            end
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 3);
                2: gap = $urandom_range(1, 20);
                default: gap = $urandom_range(20, 80);
            endcase
            if (gap > 0) begin
                idle_sender(gap);
            end
        end

        // drain
        start = 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/lpmt_pkg.sv
hw/rtl/lpmt_ctrl.sv
hw/rtl/lpmt_datapath.sv
hw/rtl/longest_prefix_match_table_top.sv
verif/testbench.sv
